FILE: rtl/mrs_pkg.sv
// Package for the motion reaction sequencer: reaction codes, register
// indexes, configuration and classification structs, and default values.
// No dependencies.
`default_nettype none

package mrs_pkg;

  // Default parameter values
  localparam int unsigned TimeWidthDef = 32;
  localparam int unsigned FracBitsDef  = 8;

  // Field widths
  localparam int unsigned MagW    = 16;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned ReactW  = 3;

  // Reaction state codes
  localparam logic [ReactW-1:0] R_IDLE    = 3'd0;
  localparam logic [ReactW-1:0] R_EXCITED = 3'd1;
  localparam logic [ReactW-1:0] R_TILT    = 3'd2;
  localparam logic [ReactW-1:0] R_DROP    = 3'd3;
  localparam logic [ReactW-1:0] R_PEAK    = 3'd4;
  localparam logic [ReactW-1:0] R_DIZZY   = 3'd5;
  localparam logic [ReactW-1:0] R_HAPPY   = 3'd6;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_GRAVITY_BASE = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_GYRO_MILD    = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_DEV_MILD     = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_TRIGGER_TILT = 8'd3;
  localparam logic [CfgIdxW-1:0] REG_GYRO_HARD    = 8'd4;
  localparam logic [CfgIdxW-1:0] REG_DEV_HARD     = 8'd5;
  localparam logic [CfgIdxW-1:0] REG_GYRO_REST    = 8'd6;
  localparam logic [CfgIdxW-1:0] REG_DEV_REST     = 8'd7;

  // Register reset values (Q8.8)
  localparam logic [MagW-1:0] GRAVITY_BASE_RST = 16'd2637;
  localparam logic [MagW-1:0] GYRO_MILD_RST    = 16'd205;
  localparam logic [MagW-1:0] DEV_MILD_RST     = 16'd230;
  localparam logic [MagW-1:0] TRIGGER_TILT_RST = 16'd3072;
  localparam logic [MagW-1:0] GYRO_HARD_RST    = 16'd1024;
  localparam logic [MagW-1:0] DEV_HARD_RST     = 16'd640;
  localparam logic [MagW-1:0] GYRO_REST_RST    = 16'd141;
  localparam logic [MagW-1:0] DEV_REST_RST     = 16'd205;

  // Hold times in ms
  localparam int unsigned HOLD_SHORT_MS  = 200;
  localparam int unsigned HOLD_SETTLE_MS = 400;
  localparam int unsigned HOLD_DIZZY_MS  = 700;
  localparam int unsigned HOLD_HAPPY_MS  = 800;
  localparam int unsigned HOLD_PEAK_MS   = 1000;
  localparam int unsigned COOLDOWN_MS    = 700;

  typedef struct packed {
    logic [MagW-1:0] gravity_base;
    logic [MagW-1:0] gyro_mild_thr;
    logic [MagW-1:0] dev_mild_thr;
    logic [MagW-1:0] trigger_tilt;
    logic [MagW-1:0] gyro_hard_thr;
    logic [MagW-1:0] dev_hard_thr;
    logic [MagW-1:0] gyro_rest_thr;
    logic [MagW-1:0] dev_rest_thr;
  } cfg_t;

  // Classes of one sample
  typedef struct packed {
    logic mild;
    logic hard;
    logic calm;
    logic upright;
    logic settled;
  } class_t;

  typedef struct packed {
    logic [ReactW-1:0] reaction;
    logic              changed;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/motion_reaction_sequencer_core.sv
// Top level of the motion reaction sequencer: input register, config
// registers, classifier, sequencer and result register.
// Depends on mrs_pkg, mrs_classify and mrs_seq.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------
//   in      | in_valid_i/in_stall_o| now_time, accel/gyro magnitude, tilt, suppress
//   out     | out_valid_o/out_stall_i | reaction, changed
//   cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One sample per cycle sustained while out_stall_i stays low; an accepted sample is held
// in the input register and its result is loaded into the result register once that
// is free, from the combinational compare and state-update path between the two.
// Reset loads the register defaults and idles.
// A stalled result holds; a new sample still enters the input register and
// waits there, and the input stalls only once both registers are full.
`default_nettype none

module motion_reaction_sequencer_core #(
  parameter int unsigned TIME_WIDTH = mrs_pkg::TimeWidthDef,
  parameter int unsigned FRAC_BITS  = mrs_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [TIME_WIDTH-1:0]         now_time_i,
  input  logic [mrs_pkg::MagW-1:0]      accel_magnitude_i,
  input  logic [mrs_pkg::MagW-1:0]      gyro_magnitude_i,
  input  logic [mrs_pkg::MagW-1:0]      tilt_angle_i,
  input  logic                          suppress_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mrs_pkg::ReactW-1:0]    reaction_o,
  output logic                          changed_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mrs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mrs_pkg::MagW-1:0]      cfg_data_i
);
  import mrs_pkg::*;

  cfg_t                  cfg_q;
  logic                  s1_valid_q;
  logic [TIME_WIDTH-1:0] s1_now_q;
  logic [MagW-1:0]       s1_accel_q, s1_gyro_q, s1_tilt_q;
  logic                  s1_suppress_q;
  logic                  out_valid_q;
  result_t               out_q;
  result_t               res;
  class_t                cls;
  logic                  out_free, s1_move, in_xfer;

  // Flow control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gravity_base  <= GRAVITY_BASE_RST;
      cfg_q.gyro_mild_thr <= GYRO_MILD_RST;
      cfg_q.dev_mild_thr  <= DEV_MILD_RST;
      cfg_q.trigger_tilt  <= TRIGGER_TILT_RST;
      cfg_q.gyro_hard_thr <= GYRO_HARD_RST;
      cfg_q.dev_hard_thr  <= DEV_HARD_RST;
      cfg_q.gyro_rest_thr <= GYRO_REST_RST;
      cfg_q.dev_rest_thr  <= DEV_REST_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_GRAVITY_BASE: cfg_q.gravity_base  <= cfg_data_i;
        REG_GYRO_MILD:    cfg_q.gyro_mild_thr <= cfg_data_i;
        REG_DEV_MILD:     cfg_q.dev_mild_thr  <= cfg_data_i;
        REG_TRIGGER_TILT: cfg_q.trigger_tilt  <= cfg_data_i;
        REG_GYRO_HARD:    cfg_q.gyro_hard_thr <= cfg_data_i;
        REG_DEV_HARD:     cfg_q.dev_hard_thr  <= cfg_data_i;
        REG_GYRO_REST:    cfg_q.gyro_rest_thr <= cfg_data_i;
        REG_DEV_REST:     cfg_q.dev_rest_thr  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_now_q      <= now_time_i;
      s1_accel_q    <= accel_magnitude_i;
      s1_gyro_q     <= gyro_magnitude_i;
      s1_tilt_q     <= tilt_angle_i;
      s1_suppress_q <= suppress_i;
    end
  end

  mrs_classify #(
    .FRAC_BITS(FRAC_BITS)
  ) u_classify (
    .cfg_i  (cfg_q),
    .accel_i(s1_accel_q),
    .gyro_i (s1_gyro_q),
    .tilt_i (s1_tilt_q),
    .cls_o  (cls)
  );

  mrs_seq #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (s1_move),
    .now_i     (s1_now_q),
    .suppress_i(s1_suppress_q),
    .cls_i     (cls),
    .res_o     (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign reaction_o  = out_q.reaction;
  assign changed_o   = out_q.changed;

endmodule

`default_nettype wire

FILE: rtl/mrs_classify.sv
// Sample classifier: accel deviation and the strict threshold compares.
// Depends on mrs_pkg.
`default_nettype none

module mrs_classify #(
  parameter int unsigned FRAC_BITS = mrs_pkg::FracBitsDef
) (
  input  mrs_pkg::cfg_t                 cfg_i,
  input  logic [mrs_pkg::MagW-1:0]      accel_i,
  input  logic [mrs_pkg::MagW-1:0]      gyro_i,
  input  logic [mrs_pkg::MagW-1:0]      tilt_i,
  output mrs_pkg::class_t               cls_o
);
  import mrs_pkg::*;

  // Peak settle limits: 3.0 and 2.5 in the chosen fixed-point format
  localparam logic [MagW:0] SettledGyro = (MagW+1)'(3) << FRAC_BITS;
  localparam logic [MagW:0] SettledDev  = (MagW+1)'(5) << (FRAC_BITS - 1);

  logic [MagW-1:0] dev;

  // |accel - gravity|, exact in 16 bits
  assign dev = (accel_i >= cfg_i.gravity_base) ? (accel_i - cfg_i.gravity_base)
                                               : (cfg_i.gravity_base - accel_i);

  assign cls_o.mild    = (gyro_i > cfg_i.gyro_mild_thr) || (dev > cfg_i.dev_mild_thr) ||
                         (tilt_i > cfg_i.trigger_tilt);
  assign cls_o.hard    = (gyro_i > cfg_i.gyro_hard_thr) || (dev > cfg_i.dev_hard_thr);
  assign cls_o.calm    = (gyro_i < cfg_i.gyro_rest_thr) && (dev < cfg_i.dev_rest_thr);
  assign cls_o.upright = tilt_i < cfg_i.trigger_tilt;
  assign cls_o.settled = ({1'b0, gyro_i} < SettledGyro) && ({1'b0, dev} < SettledDev);

endmodule

`default_nettype wire

FILE: rtl/mrs_seq.sv
// Reaction sequencer: state, timers and cooldown, updated once per sample.
// Depends on mrs_pkg.
`default_nettype none

module mrs_seq #(
  parameter int unsigned TIME_WIDTH = mrs_pkg::TimeWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [TIME_WIDTH-1:0] now_i,
  input  logic                  suppress_i,
  input  mrs_pkg::class_t       cls_i,
  output mrs_pkg::result_t      res_o
);
  import mrs_pkg::*;

  localparam logic [TIME_WIDTH-1:0] TShort  = TIME_WIDTH'(HOLD_SHORT_MS);
  localparam logic [TIME_WIDTH-1:0] TSettle = TIME_WIDTH'(HOLD_SETTLE_MS);
  localparam logic [TIME_WIDTH-1:0] TDizzy  = TIME_WIDTH'(HOLD_DIZZY_MS);
  localparam logic [TIME_WIDTH-1:0] THappy  = TIME_WIDTH'(HOLD_HAPPY_MS);
  localparam logic [TIME_WIDTH-1:0] TPeak   = TIME_WIDTH'(HOLD_PEAK_MS);
  localparam logic [TIME_WIDTH-1:0] TCool   = TIME_WIDTH'(COOLDOWN_MS);

  logic [ReactW-1:0]     state_q, state_d, next_state;
  logic [TIME_WIDTH-1:0] enter_q, enter_d;
  logic [TIME_WIDTH-1:0] settle_q, settle_d;
  logic [TIME_WIDTH-1:0] cool_q, cool_d;
  logic                  settle_valid_q, settle_valid_d;
  logic                  strong_seen_q, strong_seen_d;
  logic                  go, moved;
  logic [TIME_WIDTH-1:0] elapsed, settled_for, since_cool;

  // Wrapping elapsed times
  assign elapsed     = now_i - enter_q;
  assign settled_for = now_i - settle_q;
  assign since_cool  = now_i - cool_q;

  // Next state
  always_comb begin
    state_d        = state_q;
    enter_d        = enter_q;
    settle_d       = settle_q;
    cool_d         = cool_q;
    settle_valid_d = settle_valid_q;
    strong_seen_d  = strong_seen_q;
    next_state     = state_q;
    go             = 1'b0;
    moved          = 1'b0;
    if (suppress_i) begin
      // back to idle without a face change, cooldown kept
      state_d        = R_IDLE;
      enter_d        = now_i;
      settle_valid_d = 1'b0;
      strong_seen_d  = 1'b0;
    end else begin
      if (cls_i.hard) strong_seen_d = 1'b1;
      unique case (state_q)
        R_IDLE: begin
          if (!since_cool[TIME_WIDTH-1] && cls_i.mild) begin
            strong_seen_d = cls_i.hard;
            next_state    = R_EXCITED;
            go            = 1'b1;
          end
        end
        R_EXCITED: begin
          if (elapsed >= TShort) begin
            next_state = R_TILT;
            go         = 1'b1;
          end
        end
        R_TILT: begin
          if (strong_seen_d && (elapsed >= TShort)) begin
            next_state = R_DROP;
            go         = 1'b1;
          end else if (cls_i.calm && cls_i.upright) begin
            if (!settle_valid_q) begin
              settle_d       = now_i;
              settle_valid_d = 1'b1;
            end else if (settled_for >= TSettle) begin
              next_state = R_HAPPY;
              go         = 1'b1;
            end
          end else begin
            settle_valid_d = 1'b0;
          end
        end
        R_DROP: begin
          if (elapsed >= TShort) begin
            next_state = R_PEAK;
            go         = 1'b1;
          end
        end
        R_PEAK: begin
          if ((elapsed >= TSettle) && (cls_i.settled || (elapsed >= TPeak))) begin
            next_state = R_DIZZY;
            go         = 1'b1;
          end
        end
        R_DIZZY: begin
          if (elapsed >= TDizzy) begin
            next_state = R_HAPPY;
            go         = 1'b1;
          end
        end
        R_HAPPY: begin
          if (elapsed >= THappy) begin
            next_state    = R_IDLE;
            go            = 1'b1;
            strong_seen_d = 1'b0;
            cool_d        = now_i + TCool;
          end
        end
        default: begin
          // unused code: fall back to idle quietly
          state_d = R_IDLE;
        end
      endcase
      // state entry
      if (go) begin
        state_d        = next_state;
        enter_d        = now_i;
        settle_valid_d = 1'b0;
        moved          = 1'b1;
      end
    end
  end

  assign res_o.reaction = state_d;
  assign res_o.changed  = moved;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= R_IDLE;
      enter_q        <= '0;
      settle_q       <= '0;
      cool_q         <= '0;
      settle_valid_q <= 1'b0;
      strong_seen_q  <= 1'b0;
    end else if (fire_i) begin
      state_q        <= state_d;
      enter_q        <= enter_d;
      settle_q       <= settle_d;
      cool_q         <= cool_d;
      settle_valid_q <= settle_valid_d;
      strong_seen_q  <= strong_seen_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mrs_checker.sv
// Port-level checker for the motion reaction sequencer and its bind.
// Depends on mrs_pkg and motion_reaction_sequencer_core.
`default_nettype none

module mrs_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [mrs_pkg::ReactW-1:0] reaction_o,
  input logic                       changed_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(reaction_o) && $stable(changed_o))
    else $error("stalled result changed");

  // Input stalls only when the result register is full and stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free result slot");

  // An accepted sample reaches the output once the result slot frees
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 (!out_valid_o || !out_stall_i) |=> out_valid_o)
    else $error("accepted sample produced no result");

endmodule

bind motion_reaction_sequencer_core mrs_checker u_mrs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .reaction_o (reaction_o),
  .changed_o  (changed_o)
);

`default_nettype wire

FILE: dv/motion_reaction_sequencer_core_tb.sv
// Self-checking testbench for motion_reaction_sequencer_core: drives motion samples and
// register writes, predicts each reaction result and compares it with what the block returns.
// Depends on mrs_pkg and the RTL of motion_reaction_sequencer_core.
`default_nettype none

module motion_reaction_sequencer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mrs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_GAP   = 4;
  localparam int unsigned PEAK_MIN_MS = 400;
  // peak counts as settled below 3.0 rad/s and 2.5 m/s2 deviation
  localparam logic [MagW-1:0] SETTLED_GYRO = MagW'(3 << FracBitsDef);
  localparam logic [MagW-1:0] SETTLED_DEV  = MagW'(5 << (FracBitsDef - 1));
  localparam logic [MagW-1:0] TILT_MAX     = 16'd46080;
  localparam logic [CfgIdxW-1:0] REG_NONE  = 8'hFF;

  typedef struct packed {
    logic [31:0]     now_ms;
    logic [MagW-1:0] accel_mag;
    logic [MagW-1:0] gyro_mag;
    logic [MagW-1:0] tilt_mag;
    logic            suppress;
  } sample_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [31:0]         now_time_i;
  logic [MagW-1:0]     accel_magnitude_i;
  logic [MagW-1:0]     gyro_magnitude_i;
  logic [MagW-1:0]     tilt_angle_i;
  logic                suppress_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [ReactW-1:0]   reaction_o;
  logic                changed_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [MagW-1:0]     cfg_data_i;

  motion_reaction_sequencer_core i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .now_time_i        (now_time_i),
    .accel_magnitude_i (accel_magnitude_i),
    .gyro_magnitude_i  (gyro_magnitude_i),
    .tilt_angle_i      (tilt_angle_i),
    .suppress_i        (suppress_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .reaction_o        (reaction_o),
    .changed_o         (changed_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // Predictor state: sequence, timers and the live register copy
  cfg_t              live_cfg;
  logic [ReactW-1:0] seq_state;
  logic [31:0]       enter_ms;
  logic [31:0]       settle_ms;
  logic [31:0]       cool_end_ms;
  logic              settle_armed;
  logic              strong_latched;

  result_t     expected_reactions[$];
  int unsigned err_count;
  int unsigned cycle_count;
  logic        steady;      // no idling on either side while set
  logic [31:0] clock_ms;    // timestamp cursor of the random samples

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_reactions.size());
      $display("motion_reaction_sequencer_core_tb: FAIL");
      $finish;
    end
  end

  // Result side back-pressure
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i = !steady && ($urandom_range(0, 99) < 19);
    end
  end

  // Compare every result transfer with the oldest expectation
  always @(posedge clk_i) begin : check_results
    result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reactions.size() == 0) begin
        if (err_count < 10)
          $display("unexpected result: reaction %0d changed %0b", reaction_o, changed_o);
        err_count++;
      end else begin
        exp_res = expected_reactions.pop_front();
        if (exp_res.reaction !== reaction_o || exp_res.changed !== changed_o) begin
          if (err_count < 10)
            $display("mismatch at cycle %0d: reaction exp %0d got %0d, changed exp %0b got %0b",
                     cycle_count, exp_res.reaction, reaction_o, exp_res.changed, changed_o);
          err_count++;
        end
      end
    end
  end

  function automatic cfg_t default_cfg();
    cfg_t c;
    c.gravity_base  = GRAVITY_BASE_RST;
    c.gyro_mild_thr = GYRO_MILD_RST;
    c.dev_mild_thr  = DEV_MILD_RST;
    c.trigger_tilt  = TRIGGER_TILT_RST;
    c.gyro_hard_thr = GYRO_HARD_RST;
    c.dev_hard_thr  = DEV_HARD_RST;
    c.gyro_rest_thr = GYRO_REST_RST;
    c.dev_rest_thr  = DEV_REST_RST;
    return c;
  endfunction

  // Advance the sequence by one sample and return the reaction it reports
  function automatic result_t react_to_sample(sample_t s);
    logic [MagW-1:0]   dev;
    logic              mild, hard, calm, upright, settled;
    logic [31:0]       held, cool_left;
    logic [ReactW-1:0] nxt;
    result_t           res;
    dev = (s.accel_mag >= live_cfg.gravity_base) ? s.accel_mag - live_cfg.gravity_base
                                                  : live_cfg.gravity_base - s.accel_mag;
    // suppress forces idle silently, cooldown survives
    if (s.suppress) begin
      seq_state      = R_IDLE;
      enter_ms       = s.now_ms;
      settle_armed   = 1'b0;
      strong_latched = 1'b0;
      res.reaction   = R_IDLE;
      res.changed    = 1'b0;
      return res;
    end
    mild    = s.gyro_mag > live_cfg.gyro_mild_thr || dev > live_cfg.dev_mild_thr ||
              s.tilt_mag > live_cfg.trigger_tilt;
    hard    = s.gyro_mag > live_cfg.gyro_hard_thr || dev > live_cfg.dev_hard_thr;
    calm    = s.gyro_mag < live_cfg.gyro_rest_thr && dev < live_cfg.dev_rest_thr;
    upright = s.tilt_mag < live_cfg.trigger_tilt;
    settled = s.gyro_mag < SETTLED_GYRO && dev < SETTLED_DEV;
    held    = s.now_ms - enter_ms;
    nxt     = seq_state;
    if (hard) strong_latched = 1'b1;

    case (seq_state)
      R_IDLE: begin
        cool_left = s.now_ms - cool_end_ms;
        if (!cool_left[31] && mild) begin
          strong_latched = hard;
          nxt = R_EXCITED;
        end
      end
      R_EXCITED: if (held >= HOLD_SHORT_MS) nxt = R_TILT;
      R_TILT: begin
        if (strong_latched && held >= HOLD_SHORT_MS) begin
          nxt = R_DROP;
        end else if (calm && upright) begin
          if (!settle_armed) begin
            settle_ms    = s.now_ms;
            settle_armed = 1'b1;
          end else if (s.now_ms - settle_ms >= HOLD_SETTLE_MS) begin
            nxt = R_HAPPY;
          end
        end else begin
          settle_armed = 1'b0;
        end
      end
      R_DROP: if (held >= HOLD_SHORT_MS) nxt = R_PEAK;
      R_PEAK: if (held >= PEAK_MIN_MS && (settled || held >= HOLD_PEAK_MS)) nxt = R_DIZZY;
      R_DIZZY: if (held >= HOLD_DIZZY_MS) nxt = R_HAPPY;
      R_HAPPY: begin
        if (held >= HOLD_HAPPY_MS) begin
          nxt            = R_IDLE;
          strong_latched = 1'b0;
          cool_end_ms    = s.now_ms + COOLDOWN_MS;
        end
      end
      default: nxt = seq_state;
    endcase

    // any state entry restarts the hold timer and drops the settle timer
    res.changed = (nxt != seq_state);
    if (res.changed) begin
      seq_state    = nxt;
      enter_ms     = s.now_ms;
      settle_armed = 1'b0;
    end
    res.reaction = seq_state;
    return res;
  endfunction

  function automatic sample_t mk(logic [31:0] t, logic [MagW-1:0] a, logic [MagW-1:0] g,
                                 logic [MagW-1:0] tilt, logic sup);
    sample_t s;
    s.now_ms    = t;
    s.accel_mag = a;
    s.gyro_mag  = g;
    s.tilt_mag  = tilt;
    s.suppress  = sup;
    return s;
  endfunction

  // Random sample: mostly small time steps, class mix biased by the current state
  function automatic sample_t draw_sample();
    sample_t         s;
    int unsigned     pick;
    int unsigned     calm_share;
    logic [MagW-1:0] off;
    pick = $urandom_range(0, 99);
    if (pick < 70)      clock_ms += $urandom_range(0, 300);
    else if (pick < 80) clock_ms = clock_ms;
    else if (pick < 93) clock_ms += $urandom_range(300, 2500);
    else if (pick < 97) clock_ms = $urandom;      // jump anywhere, backwards too
    else                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 500);
    s.now_ms = clock_ms;

    calm_share = (seq_state == R_TILT || seq_state == R_PEAK) ? 60 : 35;
    pick = $urandom_range(0, 99);
    if (pick < calm_share) begin
      s.gyro_mag = MagW'($urandom_range(0, 160));
      off        = MagW'($urandom_range(0, 220));
      s.tilt_mag = MagW'($urandom_range(0, 3200));
    end else if (pick < calm_share + 25) begin
      s.gyro_mag = MagW'($urandom_range(150, 1100));
      off        = MagW'($urandom_range(0, 700));
      s.tilt_mag = MagW'($urandom_range(0, 6000));
    end else if (pick < calm_share + 45) begin
      s.gyro_mag = MagW'($urandom_range(800, 5000));
      off        = MagW'($urandom_range(0, 2000));
      s.tilt_mag = MagW'($urandom_range(0, TILT_MAX));
    end else begin
      s.gyro_mag = MagW'($urandom);
      off        = MagW'($urandom);
      s.tilt_mag = MagW'($urandom_range(0, TILT_MAX));
    end
    s.accel_mag = $urandom_range(0, 1) ? live_cfg.gravity_base + off
                                       : live_cfg.gravity_base - off;
    s.suppress  = ($urandom_range(0, 99) < 3);
    return s;
  endfunction

  // One sample transfer; called and returns just after a falling edge
  task automatic send_sample(sample_t s);
    while (!steady && $urandom_range(0, 99) < 19) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    now_time_i        = s.now_ms;
    accel_magnitude_i = s.accel_mag;
    gyro_magnitude_i  = s.gyro_mag;
    tilt_angle_i      = s.tilt_mag;
    suppress_i        = s.suppress;
    in_valid_i        = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_reactions.push_back(react_to_sample(s));
    @(negedge clk_i);
  endtask

  task automatic send_random(int unsigned count);
    repeat (count) send_sample(draw_sample());
  endtask

  // Stop sending and wait until every expected result has come back
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (expected_reactions.size() != 0) @(negedge clk_i);
    repeat (DRAIN_GAP) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [MagW-1:0] val);
    cfg_index_i = idx;
    cfg_data_i  = val;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_GRAVITY_BASE: live_cfg.gravity_base  = val;
      REG_GYRO_MILD:    live_cfg.gyro_mild_thr = val;
      REG_DEV_MILD:     live_cfg.dev_mild_thr  = val;
      REG_TRIGGER_TILT: live_cfg.trigger_tilt  = val;
      REG_GYRO_HARD:    live_cfg.gyro_hard_thr = val;
      REG_DEV_HARD:     live_cfg.dev_hard_thr  = val;
      REG_GYRO_REST:    live_cfg.gyro_rest_thr = val;
      REG_DEV_REST:     live_cfg.dev_rest_thr  = val;
      default: ;  // unknown index is dropped by the block
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic load_cfg(cfg_t c);
    drain_results();
    write_reg(REG_GRAVITY_BASE, c.gravity_base);
    write_reg(REG_GYRO_MILD,    c.gyro_mild_thr);
    write_reg(REG_DEV_MILD,     c.dev_mild_thr);
    write_reg(REG_TRIGGER_TILT, c.trigger_tilt);
    write_reg(REG_GYRO_HARD,    c.gyro_hard_thr);
    write_reg(REG_DEV_HARD,     c.dev_hard_thr);
    write_reg(REG_GYRO_REST,    c.gyro_rest_thr);
    write_reg(REG_DEV_REST,     c.dev_rest_thr);
  endtask

  // Full walks with reset registers: strong path with peak timeout, cooldown, calm settle path
  task automatic test_sequence_walk();
    logic [MagW-1:0] g;
    g = GRAVITY_BASE_RST;
    send_sample(mk(32'd0,    g, 16'd0,    16'd0, 1'b0));    // calm, stays idle
    send_sample(mk(32'd10,   g, 16'd2000, 16'd0, 1'b0));    // strong -> excited
    send_sample(mk(32'd210,  g, 16'd0,    16'd0, 1'b0));    // -> tilt
    send_sample(mk(32'd420,  g, 16'd0,    16'd0, 1'b0));    // strong seen -> drop
    send_sample(mk(32'd620,  g, 16'd0,    16'd0, 1'b0));    // -> peak
    send_sample(mk(32'd1020, g, 16'd2000, 16'd0, 1'b0));    // not settled, holds
    send_sample(mk(32'd1620, g, 16'd2000, 16'd0, 1'b0));    // peak timeout -> dizzy
    send_sample(mk(32'd2320, g, 16'd0,    16'd0, 1'b0));    // -> happy
    send_sample(mk(32'd3120, g, 16'd0,    16'd0, 1'b0));    // -> idle, cooldown starts
    send_sample(mk(32'd3200, g, 16'd300,  16'd0, 1'b0));    // mild inside cooldown
    send_sample(mk(32'd3900, g, 16'd300,  16'd0, 1'b0));    // mild only -> excited
    send_sample(mk(32'd4100, g, 16'd0,    16'd0, 1'b0));    // -> tilt
    send_sample(mk(32'd4150, g, 16'd0,    16'd0, 1'b0));    // settle timer armed
    send_sample(mk(32'd4560, g, 16'd0,    16'd0, 1'b0));    // settled -> happy
    send_sample(mk(32'd5400, g, 16'd2000, 16'd0, 1'b1));    // suppress, silent idle
  endtask

  // Field extremes, wrapping and backward timestamps, out-of-range tilt
  task automatic test_field_extremes();
    send_sample(mk(32'h0000_2000, 16'h0000, 16'h0000, 16'd0,    1'b0));
    send_sample(mk(32'h0000_2000, 16'hFFFF, 16'hFFFF, TILT_MAX, 1'b0));
    send_sample(mk(32'h0000_1000, 16'hFFFF, 16'hFFFF, TILT_MAX, 1'b0));
    send_sample(mk(32'hFFFF_FF00, GRAVITY_BASE_RST, 16'h0000, 16'hFFFF, 1'b0));
    send_sample(mk(32'hFFFF_FFFF, GRAVITY_BASE_RST, 16'h0000, 16'd0, 1'b0));
    send_sample(mk(32'h0000_0100, GRAVITY_BASE_RST, 16'h0000, 16'd0, 1'b0));
    send_sample(mk(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    clock_ms = 32'hFFFF_FFFF;
  endtask

  // Random traffic with reset registers, including a stretch without idling
  task automatic test_random_defaults();
    send_random(150);
    steady = 1'b1;
    send_random(200);
    steady = 1'b0;
    send_random(150);
  endtask

  // Sender holds off until the block is empty, then resumes
  task automatic test_drain_pause();
    send_random(30);
    drain_results();
    send_random(30);
  endtask

  // Thresholds at both ends, plus a write to an index outside the register file
  task automatic test_register_extremes();
    cfg_t c;
    c = '0;
    load_cfg(c);
    send_random(80);
    c = '1;
    c.trigger_tilt = TILT_MAX;
    load_cfg(c);
    send_random(60);
    drain_results();
    write_reg(REG_NONE, 16'h0000);
    send_random(20);
  endtask

  // Several random register settings, one near the reset values
  task automatic test_random_config();
    cfg_t c;
    repeat (3) begin
      c = cfg_t'({$urandom, $urandom, $urandom, $urandom});
      c.trigger_tilt = MagW'($urandom_range(0, TILT_MAX));
      load_cfg(c);
      send_random(120);
    end
    c = default_cfg();
    c.gravity_base  = c.gravity_base + MagW'($urandom_range(0, 600)) - 16'd300;
    c.trigger_tilt  = MagW'($urandom_range(1000, 6000));
    c.gyro_hard_thr = MagW'($urandom_range(500, 2000));
    c.gyro_rest_thr = MagW'($urandom_range(100, 300));
    load_cfg(c);
    send_random(200);
    load_cfg(default_cfg());
    send_random(100);
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    now_time_i        = '0;
    accel_magnitude_i = '0;
    gyro_magnitude_i  = '0;
    tilt_angle_i      = '0;
    suppress_i        = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = '0;
    cfg_data_i        = '0;
    err_count         = 0;
    cycle_count       = 0;
    steady            = 1'b0;
    clock_ms          = '0;
    live_cfg          = default_cfg();
    seq_state         = R_IDLE;
    enter_ms          = '0;
    settle_ms         = '0;
    cool_end_ms       = '0;
    settle_armed      = 1'b0;
    strong_latched    = 1'b0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_sequence_walk();
    test_field_extremes();
    test_random_defaults();
    test_drain_pause();
    test_register_extremes();
    test_random_config();

    drain_results();
    if (err_count == 0 && expected_reactions.size() == 0) begin
      $display("motion_reaction_sequencer_core_tb: PASS");
    end else begin
      $display("motion_reaction_sequencer_core_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
